[hdl/tli_pkg.sv]
// Package for the piecewise-linear tanh interpolator.
// Holds widths, segment limits and the base and slope tables as functions.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package tli_pkg;

  localparam int unsigned ACT_W   = 32;
  localparam int unsigned TANH_W  = 16;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned SEG_W   = 6;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned BASE_W  = 15;
  localparam int unsigned SLOPE_W = 12;

  // Index 40 is the last segment that still interpolates.
  localparam logic [IDX_W-1:0]  LAST_INDEX = 11'd40;
  // Upper half of the saturation word 0x7FFFFFFF.
  localparam logic [TANH_W-1:0] SAT_MAG    = 16'h7FFF;

  function automatic logic [BASE_W-1:0] seg_base(input logic [SEG_W-1:0] seg);
    logic [BASE_W-1:0] b;
    unique case (seg)
      6'd0:  b = 15'd0;     6'd1:  b = 15'd4075;  6'd2:  b = 15'd8025;
      6'd3:  b = 15'd11743; 6'd4:  b = 15'd15143; 6'd5:  b = 15'd18173;
      6'd6:  b = 15'd20813; 6'd7:  b = 15'd23066; 6'd8:  b = 15'd24956;
      6'd9:  b = 15'd26519; 6'd10: b = 15'd27797; 6'd11: b = 15'd28830;
      6'd12: b = 15'd29660; 6'd13: b = 15'd30322; 6'd14: b = 15'd30847;
      6'd15: b = 15'd31262; 6'd16: b = 15'd31589; 6'd17: b = 15'd31846;
      6'd18: b = 15'd32048; 6'd19: b = 15'd32206; 6'd20: b = 15'd32329;
      6'd21: b = 15'd32426; 6'd22: b = 15'd32501; 6'd23: b = 15'd32560;
      6'd24: b = 15'd32606; 6'd25: b = 15'd32642; 6'd26: b = 15'd32670;
      6'd27: b = 15'd32691; 6'd28: b = 15'd32708; 6'd29: b = 15'd32721;
      6'd30: b = 15'd32732; 6'd31: b = 15'd32740; 6'd32: b = 15'd32746;
      6'd33: b = 15'd32751; 6'd34: b = 15'd32755; 6'd35: b = 15'd32758;
      6'd36: b = 15'd32760; 6'd37: b = 15'd32762; 6'd38: b = 15'd32763;
      6'd39: b = 15'd32764; 6'd40: b = 15'd32765;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [SLOPE_W-1:0] seg_slope(input logic [SEG_W-1:0] seg);
    logic [SLOPE_W-1:0] s;
    unique case (seg)
      6'd0:  s = 12'd4075; 6'd1:  s = 12'd3950; 6'd2:  s = 12'd3718;
      6'd3:  s = 12'd3400; 6'd4:  s = 12'd3030; 6'd5:  s = 12'd2640;
      6'd6:  s = 12'd2253; 6'd7:  s = 12'd1890; 6'd8:  s = 12'd1563;
      6'd9:  s = 12'd1278; 6'd10: s = 12'd1033; 6'd11: s = 12'd830;
      6'd12: s = 12'd662;  6'd13: s = 12'd525;  6'd14: s = 12'd415;
      6'd15: s = 12'd327;  6'd16: s = 12'd257;  6'd17: s = 12'd202;
      6'd18: s = 12'd158;  6'd19: s = 12'd123;  6'd20: s = 12'd97;
      6'd21: s = 12'd75;   6'd22: s = 12'd59;   6'd23: s = 12'd46;
      6'd24: s = 12'd36;   6'd25: s = 12'd28;   6'd26: s = 12'd21;
      6'd27: s = 12'd17;   6'd28: s = 12'd13;   6'd29: s = 12'd11;
      6'd30: s = 12'd8;    6'd31: s = 12'd6;    6'd32: s = 12'd5;
      6'd33: s = 12'd4;    6'd34: s = 12'd3;    6'd35: s = 12'd2;
      6'd36: s = 12'd2;    6'd37: s = 12'd1;    6'd38: s = 12'd1;
      6'd39: s = 12'd1;    6'd40: s = 12'd2;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[hdl/tli_stream_if.sv]
// Valid/ready stream interfaces for the tanh interpolator's input and result words.
// Depends on tli_pkg for the payload widths.
`default_nettype none

interface tli_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tli_pkg::ACT_W-1:0]    activation_fixed;

  modport source (output valid, output activation_fixed, input ready);
  modport sink   (input valid, input activation_fixed, output ready);
endinterface

interface tli_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tli_pkg::TANH_W-1:0]   tanh_value;

  modport source (output valid, output tanh_value, input ready);
  modport sink   (input valid, input tanh_value, output ready);
endinterface

`default_nettype wire

[hdl/tanh_lut_interpolator.sv]
// Top level of the piecewise-linear tanh interpolator: input register, datapath, result register.
// Depends on tli_pkg, the stream interfaces in tli_stream_if and the datapath tli_core.
`default_nettype none

//  channel  | direction | payload                               | handshake
//  in_word  | in        | activation_fixed, signed 8.24, 32 bit | valid/ready
//  out_word | out       | tanh_value, signed 1.15, 16 bit       | valid/ready
//
// Throughput is one word per cycle while out_word does not stall; the
// accepting edge loads the input register, and the result register then
// loads from the single-pass datapath between them as soon as it can take
// a word.
// Reset (rst_n low, synchronous) empties both registers; payload is not reset.
// When out_word stalls, the result holds; the input register still takes a
// word as long as it is empty, so in_word.ready only drops once both
// stages are full.

module tanh_lut_interpolator (
  input  wire logic clk,
  input  wire logic rst_n,
  tli_in_if.sink    in_word,
  tli_out_if.source out_word
);

  logic                                   in_valid_r;
  logic signed [tli_pkg::ACT_W-1:0]       act_r;
  logic                                   out_valid_r;
  logic signed [tli_pkg::TANH_W-1:0]      tanh_r;
  logic signed [tli_pkg::TANH_W-1:0]      tanh_nxt;
  logic                                   out_en;
  logic                                   in_en;

  // The result register can load when empty or when its word is being taken;
  // the input register can load when empty or when it hands on its word.
  assign out_en = !out_valid_r || out_word.ready;
  assign in_en  = !in_valid_r || out_en;

  assign in_word.ready       = in_en;
  assign out_word.valid      = out_valid_r;
  assign out_word.tanh_value = tanh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_en) begin
      in_valid_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_en && in_word.valid) begin
      act_r <= in_word.activation_fixed;
    end
  end

  tli_core u_core (
    .activation_fixed (act_r),
    .tanh_value       (tanh_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && in_valid_r) begin
      tanh_r <= tanh_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/tli_core.sv]
// Combinational datapath: absolute value, segment lookup, one multiply-add, saturation, sign restore.
// Depends on tli_pkg for widths, the segment limit and the tables.
`default_nettype none

module tli_core (
  input  wire logic signed [tli_pkg::ACT_W-1:0]  activation_fixed,
  output logic signed [tli_pkg::TANH_W-1:0]      tanh_value
);

  logic                                              neg;
  logic [tli_pkg::ACT_W-1:0]                         mag;
  logic [tli_pkg::IDX_W-1:0]                         idx;
  logic [tli_pkg::SEG_W-1:0]                         seg;
  logic [tli_pkg::FRAC_W-1:0]                        frac;
  logic [tli_pkg::FRAC_W+tli_pkg::SLOPE_W-1:0]       prod;
  logic [tli_pkg::ACT_W-1:0]                         word;
  logic [tli_pkg::TANH_W-1:0]                        mag_out;

  always_comb begin
    neg  = activation_fixed[tli_pkg::ACT_W-1];
    // The most negative input negates to itself; its index is far above
    // the last segment, so it saturates like any large magnitude.
    mag  = neg ? (tli_pkg::ACT_W'(0) - $unsigned(activation_fixed))
               : $unsigned(activation_fixed);
    idx  = mag[tli_pkg::ACT_W-1 -: tli_pkg::IDX_W];
    seg  = idx[tli_pkg::SEG_W-1:0];
    frac = mag[tli_pkg::FRAC_W+4:5];
    prod = {{tli_pkg::SLOPE_W{1'b0}}, frac}
         * {{tli_pkg::FRAC_W{1'b0}}, tli_pkg::seg_slope(seg)};
    word = {1'b0, tli_pkg::seg_base(seg), 16'h0000}
         + {4'h0, prod};
    if (idx > tli_pkg::LAST_INDEX) begin
      mag_out = tli_pkg::SAT_MAG;
    end else begin
      mag_out = word[tli_pkg::ACT_W-1 -: tli_pkg::TANH_W];
    end
    tanh_value = neg ? $signed(tli_pkg::TANH_W'(0) - mag_out) : $signed(mag_out);
  end

endmodule

`default_nettype wire

[hdl/tli_checker.sv]
// Port-level checker for tanh_lut_interpolator and the bind that attaches it.
// Depends on tli_pkg for payload widths.
`default_nettype none

module tli_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [tli_pkg::TANH_W-1:0]  tanh_value
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tanh_value))
    else $error("result word changed or dropped while stalled");

  // The saturated magnitude is 32767, so -32768 never appears.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> tanh_value != 16'sh8000)
    else $error("result word outside -32767..32767");

  // With the result side empty, the block must take new input.
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused although no result is pending");

  // An accepted word reaches the output if the sink is ready in the cycle after it is taken.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted word did not reach the result register");

endmodule

bind tanh_lut_interpolator tli_checker u_tli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_word.valid),
  .in_ready   (in_word.ready),
  .out_valid  (out_word.valid),
  .out_ready  (out_word.ready),
  .tanh_value (out_word.tanh_value)
);

`default_nettype wire
